// File: rtl/core/vcoc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel column occupancy cull: shared definitions
// Field widths, register indexes, item kinds, face codes and the constants
// of the height scaling used by the core and its sub-blocks.
// ----------------------------------------------------------------------------
package vcoc_pkg;

	localparam int CEIL_W   = 16;
	localparam int LEVEL_W  = 12;
	localparam int HEIGHT_W = 16;
	localparam int TOP_W    = 16;
	localparam int POS_W    = 4;
	localparam int FACE_W   = 3;
	// Signed coordinate wide enough for a field value one step either side.
	localparam int COORD_W  = POS_W + 2;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 24;

	// Terrain height 255.0 in 8.8 fixed point.
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hFF00;

	// ceil(2^32 / 255); exact floor division by 255 for any 24-bit dividend.
	localparam int RECIP_W = 25;
	localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;

	localparam logic [CEIL_W-1:0]  CEILING_RESET = 16'd255;
	localparam logic [LEVEL_W-1:0] LEVEL_RESET   = 12'd0;

	// Register index, taken from paddr[2].
	localparam logic REG_WORLD_CEILING = 1'b0;
	localparam logic REG_CHUNK_LEVEL   = 1'b1;

	// Item kinds carried on tuser.
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	localparam logic [FACE_W-1:0] FACE_BACK   = 3'd0;
	localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd1;
	localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
	localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
	localparam logic [FACE_W-1:0] FACE_TOP    = 3'd4;
	localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd5;

	typedef struct packed {
		logic [CEIL_W-1:0]         world_ceiling;
		logic signed [LEVEL_W-1:0] chunk_level;
	} cfg_t;

endpackage

// File: rtl/core/vcoc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// APB register file holding the world ceiling and the chunk level.
// ----------------------------------------------------------------------------
module vcoc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output vcoc_pkg::cfg_t     cfg
);
	import vcoc_pkg::*;

	logic              wr_en;
	logic [CEIL_W-1:0] ceiling_q;
	logic [LEVEL_W-1:0] level_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= CEILING_RESET;
			level_q   <= LEVEL_RESET;
		end else if (wr_en) begin
			if (paddr[2] == REG_WORLD_CEILING) begin
				ceiling_q <= pwdata[CEIL_W-1:0];
			end else begin
				level_q <= pwdata[LEVEL_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_CHUNK_LEVEL) begin
			prdata = {{(32-LEVEL_W){1'b0}}, level_q};
		end else begin
			prdata = {{(32-CEIL_W){1'b0}}, ceiling_q};
		end
	end

	assign cfg.world_ceiling = ceiling_q;
	assign cfg.chunk_level   = $signed(level_q);

endmodule

// File: rtl/core/vcoc_col_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column store
// One column mask per (x,z) column in a synchronous RAM with registered read
// data, swept to zero entry by entry after reset.
// ----------------------------------------------------------------------------
module vcoc_col_store #(
	parameter int CHUNK_EDGE = 16
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       rd_en,
	input  logic [$clog2(CHUNK_EDGE*CHUNK_EDGE)-1:0]   rd_addr,
	output logic [CHUNK_EDGE-1:0]                      rd_data,
	input  logic                                       wr_en,
	input  logic [$clog2(CHUNK_EDGE*CHUNK_EDGE)-1:0]   wr_addr,
	input  logic [CHUNK_EDGE-1:0]                      wr_data,
	output logic                                       clr_busy
);
	localparam int DEPTH = CHUNK_EDGE * CHUNK_EDGE;
	localparam int AW    = $clog2(DEPTH);

	logic [CHUNK_EDGE-1:0] mem [DEPTH];
	logic [AW-1:0]         clr_addr_q;
	logic                  clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

// File: rtl/core/vcoc_top_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column top calculator
// Three-stage pipeline: clamp and scale by the ceiling, divide by 65280 via
// a reciprocal multiply, then build the column mask for the chunk level.
// ----------------------------------------------------------------------------
module vcoc_top_calc #(
	parameter int CHUNK_EDGE = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [vcoc_pkg::HEIGHT_W-1:0] height,
	input  vcoc_pkg::cfg_t                cfg,
	output logic                          valid,
	output logic [vcoc_pkg::TOP_W-1:0]    top,
	output logic [CHUNK_EDGE-1:0]         mask
);
	import vcoc_pkg::*;

	localparam int PROD_W = HEIGHT_W + CEIL_W;
	localparam int Q_W    = PROD_W - 8;
	localparam int QM_W   = Q_W + RECIP_W;
	// World row width: chunk level times edge plus a row, with sign.
	localparam int WW     = LEVEL_W + $clog2(CHUNK_EDGE) + 2;
	localparam logic signed [WW-1:0] EDGE_S = WW'(CHUNK_EDGE);

	logic [HEIGHT_W-1:0]    h_clamp;
	logic [PROD_W-1:0]      prod_s1;
	logic [QM_W-1:0]        qm_s2;
	logic [TOP_W-1:0]       top_c;
	logic signed [WW-1:0]   base_c;
	logic signed [WW-1:0]   top_ext;
	logic signed [WW-1:0]   row_w;
	logic [CHUNK_EDGE-1:0]  mask_c;
	logic [TOP_W-1:0]       top_s3;
	logic [CHUNK_EDGE-1:0]  mask_s3;
	logic                   valid_s1;
	logic                   valid_s2;
	logic                   valid_s3;

	assign h_clamp = (height > HEIGHT_MAX) ? HEIGHT_MAX : height;

	// floor(P / 65280) = floor(floor(P / 256) / 255)
	assign top_c   = qm_s2[32 +: TOP_W];
	assign base_c  = $signed({{(WW-LEVEL_W){cfg.chunk_level[LEVEL_W-1]}}, cfg.chunk_level})
		* EDGE_S;
	assign top_ext = $signed({{(WW-TOP_W){1'b0}}, top_c});

	always_comb begin
		row_w  = '0;
		mask_c = '0;
		for (int r = 0; r < CHUNK_EDGE; r++) begin
			row_w     = base_c + WW'(r);
			mask_c[r] = !row_w[WW-1] && (row_w <= top_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(h_clamp) * PROD_W'(cfg.world_ceiling);
		qm_s2   <= QM_W'(prod_s1[PROD_W-1:8]) * QM_W'(RECIP_255);
		if (valid_s2) begin
			top_s3  <= top_c;
			mask_s3 <= mask_c;
		end
	end

	assign valid = valid_s3;
	assign top   = top_s3;
	assign mask  = mask_s3;

endmodule

// File: rtl/core/voxel_column_occupancy_cull_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voxel column occupancy cull core
// Occupancy grid of one voxel chunk, one bit mask per (x,z) column, with
// column loads from terrain height and face neighbour queries.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_ stream: s_tuser is the kind (load or query), s_tdata
//   the coordinates, face and terrain height. Each item gives exactly one
//   transaction on the m_ stream: occupied, column top and the any-block flag.
//   Registers (world ceiling, chunk level) are written through the APB port; the
//   user must do so only while no item is in flight, as the block does not enforce it.
//   One item is handled at a time. A query reads its column from the store
//   and its result is registered after the store read; a load also runs the
//   3-stage height scaling pipeline and registers its result once that
//   pipeline reports, when the new mask is written back and the count of
//   non-empty columns updated. A result waits for a free output register.
//   The next item is taken in the cycle after the result is registered.
//   After reset the store is swept to zero, entry by entry, over all
//   CHUNK_EDGE*CHUNK_EDGE entries (256 by default); s_tready stays low meanwhile.
//   The result waits in an output register; while m_tready is low a new item
//   may still be accepted and processed up to the point of its result.
// ----------------------------------------------------------------------------
module voxel_column_occupancy_cull_core #(
	parameter int CHUNK_EDGE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // pos_x[3:0], pos_y[7:4], pos_z[11:8], face[14:12],
	                              // terrain_height[30:15], zero[31]
	input  logic [0:0]  s_tuser,  // action[0]
	// Output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // occupied[0], column_top[16:1], any_block[17],
	                              // zero[23:18]
);
	import vcoc_pkg::*;

	localparam int DEPTH = CHUNK_EDGE * CHUNK_EDGE;
	localparam int AW    = $clog2(DEPTH);
	localparam int YW    = $clog2(CHUNK_EDGE);
	localparam int CNT_W = AW + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	cfg_t                    cfg;
	logic                    clr_busy;
	logic [1:0]              state_q;
	logic                    accept;

	logic                    in_action;
	logic [FACE_W-1:0]       in_face;
	logic signed [COORD_W-1:0] nx;
	logic signed [COORD_W-1:0] ny;
	logic signed [COORD_W-1:0] nz;
	logic                    in_x;
	logic                    in_y;
	logic                    in_z;

	logic                    action_q;
	logic                    inside_q;
	logic [AW-1:0]           addr_q;
	logic [YW-1:0]           ybit_q;
	logic [HEIGHT_W-1:0]     height_q;
	logic                    done_q;

	logic [CHUNK_EDGE-1:0]   rd_data;
	logic                    rd_en;
	logic                    wr_en;
	logic                    calc_start;
	logic                    calc_valid;
	logic [TOP_W-1:0]        calc_top;
	logic [CHUNK_EDGE-1:0]   calc_mask;

	logic                    out_free;
	logic                    finish;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cnt_next;
	logic                    m_tvalid_q;
	logic                    occ_q;
	logic [TOP_W-1:0]        top_q;
	logic                    any_q;

	vcoc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vcoc_col_store #(
		.CHUNK_EDGE (CHUNK_EDGE)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (addr_q),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (addr_q),
		.wr_data  (calc_mask),
		.clr_busy (clr_busy)
	);

	vcoc_top_calc #(
		.CHUNK_EDGE (CHUNK_EDGE)
	) u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start),
		.height (height_q),
		.cfg    (cfg),
		.valid  (calc_valid),
		.top    (calc_top),
		.mask   (calc_mask)
	);

	assign s_tready = (state_q == ST_IDLE) && !clr_busy;
	assign accept   = s_tvalid && s_tready;

	// Neighbour coordinates of a query; a load keeps its own column.
	assign in_action = s_tuser[0];
	assign in_face   = s_tdata[14:12];

	always_comb begin
		nx = $signed({2'b00, s_tdata[3:0]});
		ny = $signed({2'b00, s_tdata[7:4]});
		nz = $signed({2'b00, s_tdata[11:8]});
		if (in_action == ACT_QUERY) begin
			case (in_face)
				FACE_BACK:   nz = nz - COORD_W'(1);
				FACE_FRONT:  nz = nz + COORD_W'(1);
				FACE_RIGHT:  nx = nx + COORD_W'(1);
				FACE_LEFT:   nx = nx - COORD_W'(1);
				FACE_TOP:    ny = ny + COORD_W'(1);
				FACE_BOTTOM: ny = ny - COORD_W'(1);
				default:     ;
			endcase
		end
	end

	assign in_x = (nx >= 0) && (int'(nx) < CHUNK_EDGE);
	assign in_y = (ny >= 0) && (int'(ny) < CHUNK_EDGE);
	assign in_z = (nz >= 0) && (int'(nz) < CHUNK_EDGE);

	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= in_action;
			inside_q <= (in_action == ACT_LOAD) ? (in_x && in_z) : (in_x && in_y && in_z);
			addr_q   <= AW'(nx) * AW'(CHUNK_EDGE) + AW'(nz);
			ybit_q   <= YW'(ny);
			height_q <= s_tdata[30:15];
		end
	end

	assign rd_en      = (state_q == ST_EXEC);
	assign calc_start = (state_q == ST_EXEC) && (action_q == ACT_LOAD);
	assign out_free   = !m_tvalid_q || m_tready;
	assign finish     = (state_q == ST_WAIT) && out_free
		&& ((action_q == ACT_QUERY) || done_q || calc_valid);
	assign wr_en      = finish && (action_q == ACT_LOAD) && inside_q;

	// Non-empty column count follows the old and new mask of a written column.
	always_comb begin
		cnt_next = cnt_q;
		if (wr_en) begin
			if ((|calc_mask) && !(|rd_data)) begin
				cnt_next = cnt_q + CNT_W'(1);
			end else if (!(|calc_mask) && (|rd_data)) begin
				cnt_next = cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_next;
			if (calc_valid) begin
				done_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			if (action_q == ACT_LOAD) begin
				occ_q <= 1'b0;
				top_q <= calc_top;
			end else begin
				occ_q <= inside_q && rd_data[ybit_q];
				top_q <= '0;
			end
			any_q <= (cnt_next != '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_DATA_W - TOP_W - 2){1'b0}}, any_q, top_q, occ_q};

	// One item at a time: acceptance closes the input until the result is registered.
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// The scaling pipeline only reports while a load waits for it.
	a_calc_owner: assert property (@(posedge clk) disable iff (!arst_n)
		calc_valid |-> ((state_q == ST_WAIT) && (action_q == ACT_LOAD)))
		else $error("column top result without a waiting load");

	// The column count cannot exceed the number of columns.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("non-empty column count out of range");

endmodule
